// ----- rtl/ear_clipping_triangulator_top_macros.svh -----
// Assertion macros for the ear clipping triangulator.
`ifndef EAR_CLIPPING_TRIANGULATOR_TOP_MACROS_SVH
`define EAR_CLIPPING_TRIANGULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ECT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("ect assertion failed");
`define ECT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("ect assertion failed");
`else
`define ECT_ASSERT_IMP(label, ante, cons)
`define ECT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/ect_pkg.sv -----
// Types and constants shared by the ear clipping triangulator.
package ect_pkg;
	localparam int MAX_VERTS = 64;
	localparam int IDX_W = $clog2(MAX_VERTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int COORD_W = 24;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = 2 * DIFF_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] opa;
		logic signed [DIFF_W-1:0] opb;
	} mul_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic has_tri;
		logic degen;
		logic dropped;
		logic last;
	} result_t;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_INIT = 13'b0000000000010,
		ST_FLA  = 13'b0000000000100,
		ST_FLD  = 13'b0000000001000,
		ST_FCD  = 13'b0000000010000,
		ST_ORP  = 13'b0000000100000,
		ST_ORQ  = 13'b0000001000000,
		ST_ORC  = 13'b0000010000000,
		ST_JSEL = 13'b0000100000000,
		ST_NXTC = 13'b0001000000000,
		ST_OUT  = 13'b0010000000000,
		ST_SHRD = 13'b0100000000000,
		ST_SHWR = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		SL_A = 2'd0,
		SL_B = 2'd1,
		SL_C = 2'd2,
		SL_T = 2'd3
	} slot_t;

	typedef enum logic [1:0] {
		OP_EAR = 2'd0,
		OP_D1  = 2'd1,
		OP_D2  = 2'd2,
		OP_D3  = 2'd3
	} orient_op_t;
endpackage

// ----- rtl/ect_mul.sv -----
// Shared registered signed multiplier for the orientation tests.
module ect_mul
	import ect_pkg::*;
(
	input  logic                     clk,
	input  mul_req_t                 req,
	output logic signed [PROD_W-1:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= req.opa * req.opb;
	end
endmodule

// ----- rtl/ear_clipping_triangulator_top.sv -----
// Ear clipping triangulator: vertex stores, remaining list and sequencer.
// Loading: one vertex per cycle while idle; s_axis_tready is low while busy.
// A final vertex starts triangulation: the remaining list is built, then each candidate
// is fetched and tested, and each containment test takes a select, a fetch and three
// orientation tests on the shared multiplier. Fewer than three vertices give no triangle.
// Reset clears control state and counts; vertex and list memories are not cleared.
`include "ear_clipping_triangulator_top_macros.svh"
module ear_clipping_triangulator_top
	import ect_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // vertex_x[23:0], vertex_y[47:24]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // corner_a[5:0], corner_b[11:6], corner_c[17:12], zero
	output logic [2:0]  m_axis_tuser,  // has_triangle[0], degenerate[1], dropped_vertices[2]
	output logic        m_axis_tlast
);
	logic signed [COORD_W-1:0] x_mem [MAX_VERTS];
	logic signed [COORD_W-1:0] y_mem [MAX_VERTS];
	logic [IDX_W-1:0] rl_mem [MAX_VERTS];

	state_t state_q;
	slot_t slot_q;
	orient_op_t op_q;
	logic [CNT_W-1:0] cnt_q, n_q, i_q, j_q;
	logic ovf_q, last_q, neg_q, pos_q;
	point_t pa_q, pb_q, pc_q, pt_q;
	logic [IDX_W-1:0] ia_q, ib_q, ic_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COORD_W-1:0] x_rd_q, y_rd_q;
	logic [IDX_W-1:0] rl_rd_q;
	result_t out_q;

	logic [CNT_W-1:0] pi, ni, ip1;
	logic [IDX_W-1:0] fetch_addr, rl_raddr;
	point_t u, v, w;
	mul_req_t mreq;
	logic accept, gt, lt;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {6'd0, out_q.c, out_q.b, out_q.a};
	assign m_axis_tuser = {out_q.dropped, out_q.degen, out_q.has_tri};
	assign m_axis_tlast = out_q.last;

	assign ip1 = i_q + CNT_W'(1);
	assign pi = (i_q == '0) ? n_q - CNT_W'(1) : i_q - CNT_W'(1);
	assign ni = (ip1 == n_q) ? '0 : ip1;
	assign gt = p_q > prod_q;
	assign lt = p_q < prod_q;

	always_comb begin
		case (slot_q)
			SL_A: fetch_addr = last_q ? IDX_W'(0) : pi[IDX_W-1:0];
			SL_B: fetch_addr = last_q ? IDX_W'(1) : i_q[IDX_W-1:0];
			SL_C: fetch_addr = last_q ? IDX_W'(2) : ni[IDX_W-1:0];
			default: fetch_addr = j_q[IDX_W-1:0];
		endcase
		rl_raddr = (state_q == ST_SHRD) ? ip1[IDX_W-1:0] : fetch_addr;
	end

	always_comb begin
		case (op_q)
			OP_EAR: begin u = pb_q; v = pc_q; w = pa_q; end
			OP_D1:  begin u = pt_q; v = pa_q; w = pb_q; end
			OP_D2:  begin u = pt_q; v = pb_q; w = pc_q; end
			default: begin u = pt_q; v = pc_q; w = pa_q; end
		endcase
		if (state_q == ST_ORP) begin
			mreq.opa = DIFF_W'(u.x) - DIFF_W'(w.x);
			mreq.opb = DIFF_W'(v.y) - DIFF_W'(w.y);
		end else begin
			mreq.opa = DIFF_W'(v.x) - DIFF_W'(w.x);
			mreq.opb = DIFF_W'(u.y) - DIFF_W'(w.y);
		end
	end

	ect_mul u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_q (prod_q)
	);

	always_ff @(posedge clk) begin
		if (accept && cnt_q < CNT_W'(MAX_VERTS)) begin
			x_mem[cnt_q[IDX_W-1:0]] <= $signed(s_axis_tdata[23:0]);
			y_mem[cnt_q[IDX_W-1:0]] <= $signed(s_axis_tdata[47:24]);
		end
		x_rd_q <= x_mem[rl_rd_q];
		y_rd_q <= y_mem[rl_rd_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			rl_mem[i_q[IDX_W-1:0]] <= i_q[IDX_W-1:0];
		end else if (state_q == ST_SHWR) begin
			rl_mem[i_q[IDX_W-1:0]] <= rl_rd_q;
		end
		rl_rd_q <= rl_mem[rl_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ORQ) begin
			p_q <= prod_q;
		end
		if (state_q == ST_FCD) begin
			case (slot_q)
				SL_A: pa_q <= '{x: x_rd_q, y: y_rd_q};
				SL_B: pb_q <= '{x: x_rd_q, y: y_rd_q};
				SL_C: pc_q <= '{x: x_rd_q, y: y_rd_q};
				default: pt_q <= '{x: x_rd_q, y: y_rd_q};
			endcase
		end
		if (state_q == ST_FLD) begin
			case (slot_q)
				SL_A: ia_q <= rl_rd_q;
				SL_B: ib_q <= rl_rd_q;
				SL_C: ic_q <= rl_rd_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= SL_A;
			op_q <= OP_EAR;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
			neg_q <= 1'b0;
			pos_q <= 1'b0;
			out_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cnt_q >= CNT_W'(MAX_VERTS)) begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							cnt_q <= '0;
							i_q <= '0;
							if (cnt_q < CNT_W'(MAX_VERTS)) begin
								n_q <= cnt_q + CNT_W'(1);
							end else begin
								n_q <= cnt_q;
							end
							if (cnt_q < CNT_W'(2)) begin
								out_q <= '{a: '0, b: '0, c: '0, has_tri: 1'b0, degen: 1'b0,
									dropped: ovf_q, last: 1'b1};
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_INIT;
							end
						end else if (cnt_q < CNT_W'(MAX_VERTS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_INIT: begin
					if (ip1 == n_q) begin
						i_q <= '0;
						slot_q <= SL_A;
						last_q <= (n_q == CNT_W'(3));
						state_q <= ST_FLA;
					end else begin
						i_q <= ip1;
					end
				end
				ST_FLA: state_q <= ST_FLD;
				ST_FLD: state_q <= ST_FCD;
				ST_FCD: begin
					case (slot_q)
						SL_A: begin slot_q <= SL_B; state_q <= ST_FLA; end
						SL_B: begin slot_q <= SL_C; state_q <= ST_FLA; end
						SL_C: begin
							if (last_q) begin
								out_q <= '{a: ia_q, b: ib_q, c: ic_q, has_tri: 1'b1,
									degen: 1'b0, dropped: ovf_q, last: 1'b1};
								state_q <= ST_OUT;
							end else begin
								op_q <= OP_EAR;
								state_q <= ST_ORP;
							end
						end
						default: begin op_q <= OP_D1; state_q <= ST_ORP; end
					endcase
				end
				ST_ORP: state_q <= ST_ORQ;
				ST_ORQ: state_q <= ST_ORC;
				ST_ORC: begin
					case (op_q)
						OP_EAR: begin
							if (gt) begin
								j_q <= '0;
								state_q <= ST_JSEL;
							end else begin
								state_q <= ST_NXTC;
							end
						end
						OP_D1: begin
							neg_q <= lt;
							pos_q <= gt;
							op_q <= OP_D2;
							state_q <= ST_ORP;
						end
						OP_D2: begin
							neg_q <= neg_q | lt;
							pos_q <= pos_q | gt;
							op_q <= OP_D3;
							state_q <= ST_ORP;
						end
						default: begin
							if ((neg_q | lt) && (pos_q | gt)) begin
								j_q <= j_q + CNT_W'(1);
								state_q <= ST_JSEL;
							end else begin
								state_q <= ST_NXTC;
							end
						end
					endcase
				end
				ST_JSEL: begin
					if (j_q == n_q) begin
						out_q <= '{a: ia_q, b: ib_q, c: ic_q, has_tri: 1'b1, degen: 1'b0,
							dropped: ovf_q, last: 1'b0};
						state_q <= ST_OUT;
					end else if (j_q == pi || j_q == i_q || j_q == ni) begin
						j_q <= j_q + CNT_W'(1);
					end else begin
						slot_q <= SL_T;
						state_q <= ST_FLA;
					end
				end
				ST_NXTC: begin
					if (ip1 == n_q) begin
						out_q <= '{a: '0, b: '0, c: '0, has_tri: 1'b0, degen: 1'b1,
							dropped: ovf_q, last: 1'b1};
						state_q <= ST_OUT;
					end else begin
						i_q <= ip1;
						slot_q <= SL_A;
						state_q <= ST_FLA;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						if (out_q.last) begin
							ovf_q <= 1'b0;
							last_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SHRD;
						end
					end
				end
				ST_SHRD: begin
					if (ip1 >= n_q) begin
						n_q <= n_q - CNT_W'(1);
						i_q <= '0;
						slot_q <= SL_A;
						last_q <= (n_q == CNT_W'(4));
						state_q <= ST_FLA;
					end else begin
						state_q <= ST_SHWR;
					end
				end
				ST_SHWR: begin
					i_q <= ip1;
					state_q <= ST_SHRD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ECT_ASSERT_IMP(a_no_load_while_out, m_axis_tvalid, !s_axis_tready)
	`ECT_ASSERT_NXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
	`ECT_ASSERT_IMP(a_scan_size, state_q == ST_JSEL, n_q >= CNT_W'(4) && n_q <= CNT_W'(MAX_VERTS))
	`ECT_ASSERT_NXT(a_ear_shifts, m_axis_tvalid && m_axis_tready && !m_axis_tlast, state_q == ST_SHRD)
endmodule
